>>> rtl/ipf_pkg.sv
// Package for the incremental prime finder: sizes, sequencer state type.
// No dependencies; used by ipf_rem_unit and incremental_prime_finder_core.
package ipf_pkg;

  localparam int MAX_PRIMES = 1024;
  localparam int VALUE_W    = 32;
  localparam int LIMIT_W    = 32;
  localparam int STORED_W   = 11;
  localparam int COUNT_W    = $clog2(MAX_PRIMES + 1);
  localparam int ADDR_W     = $clog2(MAX_PRIMES);
  localparam int BITCNT_W   = $clog2(VALUE_W);

  localparam logic [VALUE_W-1:0] FIRST_PRIME     = VALUE_W'(2);
  localparam logic [VALUE_W-1:0] FIRST_CANDIDATE = VALUE_W'(3);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET     = LIMIT_W'(65535);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_GCD_START,
    ST_GCD_WAIT,
    ST_FINISH
  } ipf_state_t;

endpackage

>>> rtl/incremental_prime_finder_core.sv
// Top level of the incremental prime finder: sequencer, prime table, result register.
// Depends on ipf_pkg and ipf_rem_unit.
//
// Usage:
//   Input channel (in_valid/in_stall/in_test_request): one transfer per request.
//   A transfer with in_test_request low is dropped and gives no result.
//   Each request with in_test_request high gives one result transfer on the
//   out_ channel: the candidate tested, whether it was prime and appended, the
//   table count after the step, and search_done when the table is full, the
//   candidate has passed the limit or has wrapped (then nothing is tested).
//   Configuration channel (cfg_valid/cfg_ready/cfg_data) writes candidate_limit;
//   cfg_ready is always high. Write it only while the block is idle.
//   Each request walks the stored primes: per prime, a table fetch and the
//   Euclid remainder steps in the shared bit-serial remainder unit, then a
//   finishing step; a done report goes straight to finishing. The table walk
//   and the remainder unit set the rate: one request in flight at a time.
//   in_stall is low only while the sequencer is idle. A result waits in the
//   output register while out_stall is high; the next request is accepted
//   meanwhile and its result is held back until the register frees.
//   Reset (rst_n low, synchronous): table count 1 with entry 0 reading as 2,
//   candidate 3, limit 65535, no result pending. No clearing pass.
module incremental_prime_finder_core import ipf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_test_request,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VALUE_W-1:0]  out_candidate_value,
  output logic                out_found_prime,
  output logic [STORED_W-1:0] out_primes_stored,
  output logic                out_search_done,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LIMIT_W-1:0]  cfg_data
);

  ipf_state_t state_r, state_nxt;

  logic [LIMIT_W-1:0]  limit_r;
  logic [COUNT_W-1:0]  count_r;
  logic [VALUE_W-1:0]  cand_r;
  logic                wrapped_r;
  logic [COUNT_W-1:0]  j_r;
  logic                prime_r;
  logic                is_done_r;
  logic [VALUE_W-1:0]  gb_r;
  logic [VALUE_W-1:0]  rd_data_r;
  logic [VALUE_W-1:0]  table_mem [MAX_PRIMES];

  logic                out_valid_r;
  logic [VALUE_W-1:0]  out_cand_r;
  logic                out_prime_r;
  logic [STORED_W-1:0] out_stored_r;
  logic                out_done_r;

  logic                in_xfer;
  logic                out_xfer;
  logic                out_free;
  logic                search_over;
  logic [VALUE_W-1:0]  p_val;
  logic                last_prime;
  logic                rem_start;
  logic [VALUE_W-1:0]  rem_dividend;
  logic [VALUE_W-1:0]  rem_divisor;
  logic                rem_done;
  logic [VALUE_W-1:0]  rem_value;
  logic                rem_is_zero;
  logic                rem_is_one;
  logic                gcd_coprime;
  logic                gcd_common;
  logic                finish_fire;
  logic                table_we;
  logic [COUNT_W-1:0]  count_inc;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign search_over = (count_r >= COUNT_W'(MAX_PRIMES)) || wrapped_r ||
                       (LIMIT_W'(cand_r) > limit_r);

  // entry 0 is the seed prime and never comes from the memory
  assign p_val      = (j_r == '0) ? FIRST_PRIME : rd_data_r;
  assign last_prime = (j_r + 1'b1) >= count_r;
  assign count_inc  = count_r + 1'b1;

  // remainder 1 means gcd 1; remainder 0 ends Euclid with gcd in gb_r
  assign rem_is_zero = (rem_value == '0);
  assign rem_is_one  = (rem_value == VALUE_W'(1));
  assign gcd_coprime = rem_done && (rem_is_one || (rem_is_zero && gb_r == VALUE_W'(1)));
  assign gcd_common  = rem_done && rem_is_zero && (gb_r != VALUE_W'(1));

  ipf_rem_unit u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (rem_dividend),
    .divisor   (rem_divisor),
    .done      (rem_done),
    .remainder (rem_value)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_test_request) begin
          state_nxt = search_over ? ST_FINISH : ST_FETCH;
        end
      end
      ST_FETCH:     state_nxt = ST_GCD_START;
      ST_GCD_START: state_nxt = ST_GCD_WAIT;
      ST_GCD_WAIT: begin
        if (gcd_common || (gcd_coprime && last_prime)) begin
          state_nxt = ST_FINISH;
        end else if (gcd_coprime) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall     = 1'b1;
    rem_start    = 1'b0;
    rem_dividend = gb_r;
    rem_divisor  = rem_value;
    finish_fire  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_FETCH: ;
      ST_GCD_START: begin
        rem_start    = 1'b1;
        rem_dividend = cand_r;
        rem_divisor  = p_val;
      end
      ST_GCD_WAIT: begin
        // keep stepping Euclid: next pair is (old divisor, remainder)
        rem_start = rem_done && !rem_is_zero && !rem_is_one;
      end
      ST_FINISH: finish_fire = out_free;
      default: ;
    endcase
  end

  assign table_we = finish_fire && !is_done_r && prime_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= LIMIT_RESET;
      count_r     <= COUNT_W'(1);
      cand_r      <= FIRST_CANDIDATE;
      wrapped_r   <= 1'b0;
      j_r         <= '0;
      prime_r     <= 1'b0;
      is_done_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (state_r == ST_IDLE && in_xfer && in_test_request) begin
        j_r       <= '0;
        prime_r   <= 1'b1;
        is_done_r <= search_over;
      end
      if (state_r == ST_GCD_WAIT) begin
        if (gcd_common) begin
          prime_r <= 1'b0;
        end else if (gcd_coprime && !last_prime) begin
          j_r <= j_r + 1'b1;
        end
      end
      if (finish_fire && !is_done_r) begin
        if (prime_r) begin
          count_r <= count_inc;
        end
        if (cand_r == '1) begin
          wrapped_r <= 1'b1;
        end else begin
          cand_r <= cand_r + 1'b1;
        end
      end
      // load wins over drain: a new result replaces the one just taken
      if (finish_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (state_r == ST_GCD_START) begin
      gb_r <= p_val;
    end else if (state_r == ST_GCD_WAIT && rem_start) begin
      gb_r <= rem_value;
    end
    if (finish_fire) begin
      if (is_done_r) begin
        out_cand_r   <= '0;
        out_prime_r  <= 1'b0;
        out_stored_r <= STORED_W'(count_r);
        out_done_r   <= 1'b1;
      end else begin
        out_cand_r   <= cand_r;
        out_prime_r  <= prime_r;
        out_stored_r <= prime_r ? STORED_W'(count_inc) : STORED_W'(count_r);
        out_done_r   <= 1'b0;
      end
    end
  end

  // prime table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (table_we) begin
      table_mem[count_r[ADDR_W-1:0]] <= cand_r;
    end
    rd_data_r <= table_mem[j_r[ADDR_W-1:0]];
  end

  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_candidate_value = out_cand_r;
  assign out_found_prime     = out_prime_r;
  assign out_primes_stored   = out_stored_r;
  assign out_search_done     = out_done_r;

  // the table never grows past its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(MAX_PRIMES))
    else $error("prime count exceeds table depth");

  // the count only moves up by one, and only on a finishing step
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + 1'b1) && $past(finish_fire))
    else $error("prime count moved outside a finishing step");

  // a remainder result only arrives while the sequencer waits for it
  a_rem_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> (state_r == ST_GCD_WAIT))
    else $error("remainder done outside gcd wait");

  // a result is never both a new prime and a done report
  a_out_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_prime_r && out_done_r))
    else $error("result flags prime and done together");

endmodule

>>> rtl/ipf_rem_unit.sv
// Shared remainder unit: restoring division, one quotient bit per cycle.
// Depends on ipf_pkg for VALUE_W and BITCNT_W.
module ipf_rem_unit import ipf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] dividend,
  input  logic [VALUE_W-1:0] divisor,
  output logic               done,
  output logic [VALUE_W-1:0] remainder
);

  logic                busy_r;
  logic                done_r;
  logic [BITCNT_W-1:0] cnt_r;
  logic [VALUE_W-1:0]  shift_r;
  logic [VALUE_W-1:0]  div_r;
  logic [VALUE_W-1:0]  rem_r;
  logic [VALUE_W:0]    trial;
  logic [VALUE_W:0]    diff;
  logic [VALUE_W-1:0]  rem_nxt;

  // bring down the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_r, shift_r[VALUE_W-1]};
    diff  = trial - {1'b0, div_r};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = diff[VALUE_W-1:0];
    end else begin
      rem_nxt = trial[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= BITCNT_W'(VALUE_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_r <= dividend;
      div_r   <= divisor;
      rem_r   <= '0;
    end else if (busy_r) begin
      shift_r <= {shift_r[VALUE_W-2:0], 1'b0};
      rem_r   <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
